[sv/ugbt_pkg.sv]
package ugbt_pkg;

    localparam int MAX_CELLS      = 4096;
    localparam int SLOTS_PER_CELL = 16;
    localparam int ITEM_BITS      = 16;
    localparam int CELL_BITS      = $clog2(MAX_CELLS);
    localparam int SLOT_BITS      = $clog2(SLOTS_PER_CELL);
    localparam int FILL_BITS      = $clog2(SLOTS_PER_CELL + 1);

    localparam logic [2:0] CMD_LOCATE    = 3'd0;
    localparam logic [2:0] CMD_INSERT    = 3'd1;
    localparam logic [2:0] CMD_QUERY     = 3'd2;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;
    localparam logic [2:0] CMD_NEIGHBOUR = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] REG_EDGE_SIZE  = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        cell_id;
        logic [15:0]        item_id;
        logic [2:0]         neighbour_select;
    } cmd_word_t;

    typedef struct packed {
        logic [11:0] cell_out;
        logic        cell_valid;
        logic [1:0]  status;
        logic        occupied;
    } result_word_t;

    // Divider control between sequencer and shared divider.
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;

endpackage

[sv/ugbt_divider.sv]
module ugbt_divider
    import ugbt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [15:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;

    // One restoring step per cycle: shift in a dividend bit, subtract if it fits.
    assign trial = {rem_reg, quo_reg[15]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= 16'(trial - {1'b0, dsr_reg});
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[sv/uniform_grid_bucket_table.sv]
// Grid bucket table, one command at a time. busy rises the cycle after start
// is taken and falls when the result strobe fires; results cannot be stalled.
// Insert, query, clear cell and the unused codes pass through the read, update
// and done states; neighbour and locate wait on the shared 16-step restoring
// divider (neighbour uses one division by row_length, locate two by cell_size;
// an out-of-range neighbour cell does not wait for the quotient). Clear all and
// the reset clearing pass sweep the 4096-entry fill-count memory one entry a
// cycle; busy stays high through the pass after reset.
module uniform_grid_bucket_table
    import ugbt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  cmd_word_t    cmd,
    output logic         done,
    output result_word_t result,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_DIVX  = 4'd4;
    localparam logic [3:0] S_WAITX = 4'd5;
    localparam logic [3:0] S_DIVY  = 4'd6;
    localparam logic [3:0] S_WAITY = 4'd7;
    localparam logic [3:0] S_MULT  = 4'd8;
    localparam logic [3:0] S_DIVN  = 4'd9;
    localparam logic [3:0] S_WAITN = 4'd10;
    localparam logic [3:0] S_NBR   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]  state_reg;
    logic [6:0]  row_length_reg, row_count_reg;
    logic [15:0] edge_size_reg;
    cmd_word_t   cmd_reg;
    logic        clear_all_reg;
    logic [CELL_BITS-1:0] sweep_reg;
    logic [5:0]  gx_reg, gy_reg;
    logic [5:0]  col_reg, row_reg;
    logic [FILL_BITS-1:0] fill_rd_reg;
    result_word_t res_reg;
    logic        done_reg;

    logic [FILL_BITS-1:0] fill_mem [MAX_CELLS];
    logic [ITEM_BITS-1:0] item_mem [MAX_CELLS*SLOTS_PER_CELL];

    logic [6:0]  rl, rc;
    logic [15:0] cs;
    logic [12:0] ncells;
    logic        in_range;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic [5:0]  gq;
    logic [11:0] cell_mul;
    logic        nb_ok;
    logic [5:0]  nr, nc;
    logic [1:0]  dyc, dxc;

    assign rl = (row_length_reg == 7'd0) ? 7'd1 :
                (row_length_reg > 7'd64) ? 7'd64 : row_length_reg;
    assign rc = (row_count_reg == 7'd0) ? 7'd1 :
                (row_count_reg > 7'd64) ? 7'd64 : row_count_reg;
    assign cs = (edge_size_reg == 16'd0) ? 16'd1 : edge_size_reg;
    assign ncells = {6'd0, rl} * {6'd0, rc};
    assign in_range = {1'b0, cmd_reg.cell_id} < ncells;

    ugbt_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = cs;
        unique case (state_reg)
            S_DIVX:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = cmd_reg.pos_x[15] ? 16'd0 : cmd_reg.pos_x;
            end
            S_DIVY:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = cmd_reg.pos_y[15] ? 16'd0 : cmd_reg.pos_y;
            end
            S_DIVN:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = {4'd0, cmd_reg.cell_id};
                dreq.divisor  = {9'd0, rl};
            end
            default: ;
        endcase
    end

    // Clamp a quotient to the axis length n-1 (n at most 64).
    function automatic logic [5:0] clamp_axis(input logic [15:0] q, input logic [6:0] n);
        logic [15:0] lim;
        lim = {9'd0, n} - 16'd1;
        return (q > lim) ? lim[5:0] : q[5:0];
    endfunction

    assign gq = clamp_axis(drsp.quotient,
                           (state_reg == S_WAITY) ? rc : rl);
    assign cell_mul = {6'd0, gy_reg} * {5'd0, rl} + {6'd0, gx_reg};

    always_comb
    begin
        dyc = (cmd_reg.neighbour_select < 3'd3) ? 2'd0 :
              (cmd_reg.neighbour_select < 3'd5) ? 2'd1 : 2'd2;
        unique case (cmd_reg.neighbour_select) inside
            3'd0, 3'd5: dxc = 2'd0;
            3'd1, 3'd6: dxc = 2'd1;
            3'd3:       dxc = 2'd0;
            default:    dxc = 2'd2;
        endcase
        nb_ok = 1'b1;
        if (dyc == 2'd0 && row_reg == 6'd0) nb_ok = 1'b0;
        if (dyc == 2'd2 && ({1'b0, row_reg} + 7'd1 >= rc)) nb_ok = 1'b0;
        if (dxc == 2'd0 && col_reg == 6'd0) nb_ok = 1'b0;
        if (dxc == 2'd2 && ({1'b0, col_reg} + 7'd1 >= rl)) nb_ok = 1'b0;
        nr = row_reg + {4'd0, dyc} - 6'd1;
        nc = col_reg + {4'd0, dxc} - 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= 7'd64;
            row_count_reg  <= 7'd64;
            edge_size_reg  <= 16'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_LENGTH: row_length_reg <= cfg_data[6:0];
                REG_ROW_COUNT:  row_count_reg  <= cfg_data[6:0];
                REG_EDGE_SIZE:  edge_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            done_reg      <= 1'b0;
            clear_all_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        unique case (cmd.command)
                            CMD_LOCATE:    state_reg <= S_DIVX;
                            CMD_CLEAR_ALL: state_reg <= S_SWEEP;
                            CMD_NEIGHBOUR: state_reg <= S_DIVN;
                            default:       state_reg <= S_READ;
                        endcase
                        sweep_reg     <= '0;
                        clear_all_reg <= (cmd.command == CMD_CLEAR_ALL);
                    end
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (&sweep_reg)
                        state_reg <= clear_all_reg ? S_DONE : S_IDLE;
                end
                S_READ:  state_reg <= S_UPD;
                S_UPD:   state_reg <= S_DONE;
                S_DIVX:  state_reg <= S_WAITX;
                S_WAITX: if (drsp.done) state_reg <= S_DIVY;
                S_DIVY:  state_reg <= S_WAITY;
                S_WAITY: if (drsp.done) state_reg <= S_MULT;
                S_MULT:  state_reg <= S_DONE;
                S_DIVN:  state_reg <= in_range ? S_WAITN : S_DONE;
                S_WAITN: if (drsp.done) state_reg <= S_NBR;
                S_NBR:   state_reg <= S_DONE;
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload and memories. The reset pass is told apart from clear all by
    // clear_all_reg, since cmd_reg holds nothing yet after reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
            res_reg <= '0;
        end
        if (state_reg == S_SWEEP)
            fill_mem[sweep_reg] <= '0;
        if (state_reg == S_READ)
            fill_rd_reg <= fill_mem[cmd_reg.cell_id];
        if (state_reg == S_UPD)
        begin
            unique case (cmd_reg.command)
                CMD_INSERT:
                    if (!in_range)
                        res_reg.status <= ST_RANGE;
                    else if (fill_rd_reg >= FILL_BITS'(SLOTS_PER_CELL))
                        res_reg.status <= ST_FULL;
                    else
                    begin
                        item_mem[{cmd_reg.cell_id, fill_rd_reg[SLOT_BITS-1:0]}]
                            <= cmd_reg.item_id;
                        fill_mem[cmd_reg.cell_id] <= fill_rd_reg + 1'b1;
                    end
                CMD_QUERY:
                    if (!in_range) res_reg.status <= ST_RANGE;
                    else res_reg.occupied <= (fill_rd_reg != '0);
                CMD_CLEAR:
                    if (!in_range) res_reg.status <= ST_RANGE;
                    else fill_mem[cmd_reg.cell_id] <= '0;
                default: ;
            endcase
        end
        if (state_reg == S_WAITX && drsp.done) gx_reg <= gq;
        if (state_reg == S_WAITY && drsp.done) gy_reg <= gq;
        if (state_reg == S_MULT)
        begin
            res_reg.cell_out   <= cell_mul;
            res_reg.cell_valid <= 1'b1;
        end
        if (state_reg == S_DIVN && !in_range) res_reg.status <= ST_RANGE;
        if (state_reg == S_WAITN && drsp.done)
        begin
            row_reg <= drsp.quotient[5:0];
            col_reg <= drsp.remainder[5:0];
        end
        if (state_reg == S_NBR && nb_ok)
        begin
            res_reg.cell_out   <= {6'd0, nr} * {5'd0, rl} + {6'd0, nc};
            res_reg.cell_valid <= 1'b1;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTH
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE) else $error("strobe without done state");
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy while strobing");
    a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |=> !dreq.start) else $error("divider restarted");
`endif

endmodule
